/* rtl/dvm_pkg.sv */
// ----------------------------------------------------------------------------
// Divided voltage monitor package
// Field widths, register codes and reset values shared by the monitor RTL.
// ----------------------------------------------------------------------------
package dvm_pkg;

  // Payload and register widths.
  localparam int SAMPLE_W  = 10;
  localparam int GAIN_W    = 32;
  localparam int THRESH_W  = 16;
  localparam int OFFSET_W  = 12;
  localparam int MV_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Largest code the converter can deliver on its 10-bit port.
  localparam int SAMPLE_MAX = 1023;

  // Scaled millivolts keep the integer part of average * Q16 gain.
  localparam int GAIN_FRAC_W = 16;
  localparam int SCALE_PROD_W = SAMPLE_W + GAIN_W;
  localparam int MV_FULL_W = SCALE_PROD_W - GAIN_FRAC_W;

  // Filter state carries two fraction bits below the millivolt value.
  localparam int FILT_W = MV_W + 2;
  localparam int EMA_SUM_W = FILT_W + 2;

  // Register reset values.
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 32'd327680;
  localparam logic [THRESH_W-1:0] THRESH_RST = 16'd500;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 12'd700;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_GAIN   = 2'd0,
    CFG_ZERO_THRESH  = 2'd1,
    CFG_DIODE_OFFSET = 2'd2,
    CFG_GND_OFFSET   = 2'd3
  } cfg_reg_t;

endpackage

/* rtl/divided_voltage_monitor.sv */
// ----------------------------------------------------------------------------
// Divided voltage monitor
// Boxcar average of converter samples, Q16 scaling to millivolts, diode
// offset correction and a quarter-weight moving average filter.
//
// Samples arrive on the in_ channel; a beat is taken when in_valid is high
// and in_stall is low. Every SAMPLES_PER_AVERAGE samples form one group,
// and out_valid rises for that group's beat. Samples that do not close a
// group produce nothing. The block takes one sample per cycle unless
// stalled; the four-stage pipe (sum, divide, scale, filter) has each stage
// advancing on its own, so bubbles are squeezed out. A stalled output holds
// its beat; in_stall rises only for a group-closing sample while the whole
// pipe is full behind a stalled receiver. Registers are written on the cfg_
// channel, always ready; the user must write them only while the block is
// idle, which the block does not enforce. Synchronous reset clears the
// running sum, count, filter and pipe, and restores the register defaults.
// ----------------------------------------------------------------------------
module divided_voltage_monitor #(
  parameter int SAMPLES_PER_AVERAGE = 5,
  parameter int ADC_FULL_SCALE = 1023
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Sample channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dvm_pkg::SAMPLE_W-1:0]       in_adc_sample,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [dvm_pkg::MV_W-1:0]           out_voltage_mv,
  output logic                               out_below_threshold,
  // Configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dvm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dvm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Group sum width covers a full group of largest samples.
  localparam int SUM_W = $clog2(SAMPLES_PER_AVERAGE * dvm_pkg::SAMPLE_MAX + 1);
  localparam int CNT_W = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);

  // Division by the group size is a multiply by a rounded-up reciprocal.
  // With this shift the quotient is exact for every sum that can occur.
  localparam int RCP_SH = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
  localparam int RCP_W  = RCP_SH + 1;
  localparam logic [RCP_W-1:0] RCP_MUL =
    RCP_W'((2 ** RCP_SH + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
  localparam int DIV_PROD_W = SUM_W + RCP_W;

  localparam int FS_W = 12;
  localparam logic [FS_W-1:0] FULL_SCALE = FS_W'(ADC_FULL_SCALE);

  localparam int MV_SUM_W = dvm_pkg::MV_FULL_W + 1;

  // Configuration registers.
  logic [dvm_pkg::GAIN_W-1:0]   gain_r;
  logic [dvm_pkg::THRESH_W-1:0] thresh_r;
  logic [dvm_pkg::OFFSET_W-1:0] offset_r;
  logic                         gnd_en_r;

  // Accumulator state.
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Pipe stages: closed group sum, average, scaled millivolts, result.
  logic                              grp_vld_r, avg_vld_r, mv_vld_r, out_vld_r;
  logic [SUM_W-1:0]                  grp_sum_r;
  logic [dvm_pkg::SAMPLE_W-1:0]      avg_r, avg_nxt;
  logic [dvm_pkg::MV_FULL_W-1:0]     mv_r, mv_nxt;
  logic [dvm_pkg::MV_W-1:0]          volt_r;
  logic                              below_r;
  logic [dvm_pkg::FILT_W-1:0]        filt_r, filt_nxt;

  logic                              out_rdy, mv_rdy, avg_rdy, grp_rdy;
  logic                              in_take, in_last;
  logic [dvm_pkg::SAMPLE_W-1:0]      sample_c;
  logic [DIV_PROD_W-1:0]             div_prod;
  logic [dvm_pkg::SCALE_PROD_W-1:0]  scale_prod;
  logic                              below_nxt;
  logic [MV_SUM_W-1:0]               mv_sum;
  logic [dvm_pkg::MV_W-1:0]          mv_clamp;
  logic [dvm_pkg::EMA_SUM_W-1:0]     ema_sum;

  // Each stage moves when it is empty or the stage after it moves.
  assign out_rdy = !out_vld_r || !out_stall;
  assign mv_rdy  = !mv_vld_r  || out_rdy;
  assign avg_rdy = !avg_vld_r || mv_rdy;
  assign grp_rdy = !grp_vld_r || avg_rdy;

  // Only the sample that closes a group needs room in the pipe.
  assign in_last  = (cnt_r == CNT_LAST);
  assign in_stall = in_last && !grp_rdy;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  // Samples above the converter's stated full scale are clamped to it.
  always_comb begin
    if ({{(FS_W - dvm_pkg::SAMPLE_W){1'b0}}, in_adc_sample} > FULL_SCALE) begin
      sample_c = FULL_SCALE[dvm_pkg::SAMPLE_W-1:0];
    end else begin
      sample_c = in_adc_sample;
    end
  end

  always_comb begin
    sum_nxt = sum_r + SUM_W'(sample_c);
    cnt_nxt = cnt_r + CNT_W'(1);
  end

  always_comb begin
    div_prod   = DIV_PROD_W'(grp_sum_r) * DIV_PROD_W'(RCP_MUL);
    avg_nxt    = div_prod[RCP_SH +: dvm_pkg::SAMPLE_W];
    scale_prod = dvm_pkg::SCALE_PROD_W'(avg_r) * dvm_pkg::SCALE_PROD_W'(gain_r);
    mv_nxt     = scale_prod[dvm_pkg::SCALE_PROD_W-1:dvm_pkg::GAIN_FRAC_W];
  end

  // Threshold test on the full scaled value, then offsets, clamp and filter.
  always_comb begin
    below_nxt = (mv_r <= dvm_pkg::MV_FULL_W'(thresh_r));
    mv_sum = MV_SUM_W'(mv_r) + MV_SUM_W'(offset_r)
           + (gnd_en_r ? MV_SUM_W'(offset_r) : MV_SUM_W'(0));
    if (|mv_sum[MV_SUM_W-1:dvm_pkg::MV_W]) begin
      mv_clamp = '1;
    end else begin
      mv_clamp = mv_sum[dvm_pkg::MV_W-1:0];
    end
    // New filter value is x + 3/4 of the old one, in quarter millivolts.
    ema_sum = dvm_pkg::EMA_SUM_W'({mv_clamp, 2'b00})
            + dvm_pkg::EMA_SUM_W'(filt_r)
            + dvm_pkg::EMA_SUM_W'({filt_r, 1'b0});
    if (below_nxt) begin
      filt_nxt = '0;
    end else begin
      filt_nxt = ema_sum[dvm_pkg::EMA_SUM_W-1:2];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= dvm_pkg::GAIN_RST;
      thresh_r <= dvm_pkg::THRESH_RST;
      offset_r <= dvm_pkg::OFFSET_RST;
      gnd_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dvm_pkg::cfg_reg_t'(cfg_index))
        dvm_pkg::CFG_SCALE_GAIN:   gain_r   <= cfg_data;
        dvm_pkg::CFG_ZERO_THRESH:  thresh_r <= cfg_data[dvm_pkg::THRESH_W-1:0];
        dvm_pkg::CFG_DIODE_OFFSET: offset_r <= cfg_data[dvm_pkg::OFFSET_W-1:0];
        dvm_pkg::CFG_GND_OFFSET:   gnd_en_r <= cfg_data[0];
      endcase
    end
  end

  // Accumulator and pipe control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      cnt_r     <= '0;
      grp_vld_r <= 1'b0;
      avg_vld_r <= 1'b0;
      mv_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      filt_r    <= '0;
    end else begin
      if (in_take) begin
        if (in_last) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_nxt;
        end
      end
      if (grp_rdy) begin
        grp_vld_r <= in_take && in_last;
      end
      if (avg_rdy) begin
        avg_vld_r <= grp_vld_r;
      end
      if (mv_rdy) begin
        mv_vld_r <= avg_vld_r;
      end
      if (out_rdy) begin
        out_vld_r <= mv_vld_r;
      end
      if (out_rdy && mv_vld_r) begin
        filt_r <= filt_nxt;
      end
    end
  end

  // Pipe payload.
  always_ff @(posedge clk) begin
    if (grp_rdy && in_take && in_last) begin
      grp_sum_r <= sum_nxt;
    end
    if (avg_rdy && grp_vld_r) begin
      avg_r <= avg_nxt;
    end
    if (mv_rdy && avg_vld_r) begin
      mv_r <= mv_nxt;
    end
    if (out_rdy && mv_vld_r) begin
      volt_r  <= filt_nxt[dvm_pkg::FILT_W-1:2];
      below_r <= below_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_voltage_mv      = volt_r;
  assign out_below_threshold = below_r;

`ifndef ASSERT_OFF
  // The input only waits on a group-closing sample.
  a_stall_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_last)
    else $error("input stalled on a sample that does not close a group");

  // The sample counter never reaches the group size.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) < SAMPLES_PER_AVERAGE)
    else $error("sample counter ran past the group size");

  // A result at or below threshold reports zero millivolts.
  a_below_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && below_r) |-> (volt_r == '0))
    else $error("below-threshold result carries a nonzero voltage");

  // The shown voltage is the integer part of the filter state.
  a_out_matches_filt: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (volt_r == filt_r[dvm_pkg::FILT_W-1:2]))
    else $error("output voltage differs from filter state");

  // A below-threshold group clears the filter.
  a_filt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rdy && mv_vld_r && below_nxt) |=> (filt_r == '0))
    else $error("filter not cleared after a below-threshold group");
`endif

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Divided voltage monitor testbench
// Streams converter samples through the monitor under random source gaps and
// sink stalls. A cycle-free predictor sums the groups, scales, applies the
// threshold, diode offsets and the quarter-weight filter, then every result
// beat is checked against the oldest prediction. Register settings change
// between phases, the extremes of every register among them.
// ----------------------------------------------------------------------------
module tb_top;

  // The block is built with its usual group size and converter range; the
  // predictor keeps its own copies of both.
  localparam int GROUP_LEN       = 5;
  localparam int FULL_SCALE_CODE = 1023;
  localparam int MV_CEIL         = 65535;

  // The last result still has to cross the pipe after its group closes; the
  // settle wait before a register write leaves a comfortable margin for it.
  localparam int SETTLE_CYCLES = 8;

  // Longest honest quiet stretch is a long source gap next to a long sink
  // stall plus the pipe; this limit is many times that.
  localparam int STALL_LIMIT = 2000;

  // One expected result beat.
  typedef struct packed {
    logic [dvm_pkg::MV_W-1:0] voltage_mv;
    logic                     below_threshold;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [dvm_pkg::SAMPLE_W-1:0]   in_adc_sample = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [dvm_pkg::MV_W-1:0]       out_voltage_mv;
  logic                           out_below_threshold;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [dvm_pkg::CFG_IDX_W-1:0]  cfg_index = dvm_pkg::CFG_SCALE_GAIN;
  logic [dvm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  divided_voltage_monitor #(
    .SAMPLES_PER_AVERAGE(GROUP_LEN),
    .ADC_FULL_SCALE(FULL_SCALE_CODE)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_adc_sample(in_adc_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_voltage_mv(out_voltage_mv),
    .out_below_threshold(out_below_threshold),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the register copies and the running group and filter.
  // --------------------------------------------------------------------------
  logic [dvm_pkg::GAIN_W-1:0]   gain_q16       = dvm_pkg::GAIN_RST;
  logic [dvm_pkg::THRESH_W-1:0] zero_thresh_mv = dvm_pkg::THRESH_RST;
  logic [dvm_pkg::OFFSET_W-1:0] diode_mv       = dvm_pkg::OFFSET_RST;
  logic                         ground_twice   = 1'b0;

  logic [12:0]                group_sum  = '0;
  int unsigned                group_fill = 0;
  logic [dvm_pkg::FILT_W-1:0] ema_q2     = '0;

  reading_t                      expected_readings[$];
  logic [dvm_pkg::SAMPLE_W-1:0]  sample_backlog[$];
  reading_t                      want;

  // Bookkeeping for the idle test, the verdict and the summary.
  int unsigned samples_queued = 0;
  int unsigned samples_taken  = 0;
  int unsigned readings_seen  = 0;
  int unsigned below_seen     = 0;
  int unsigned clamped_count  = 0;
  int unsigned settings_used  = 1;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned in_gap         = 0;
  int unsigned stall_left     = 0;
  bit          no_idle        = 1'b0;

  // Folds one accepted sample into the running group. A closing sample turns
  // the group average into millivolts and either clears the filter (at or
  // below threshold) or adds the diode drop once or twice, clamps to the
  // 16-bit range and moves the filter a quarter of the way toward it.
  task automatic fold_sample(input logic [dvm_pkg::SAMPLE_W-1:0] code);
    logic [dvm_pkg::SAMPLE_W-1:0] clipped;
    logic [63:0]                  avg;
    logic [63:0]                  mv;
    logic [63:0]                  mix;
    reading_t                     r;
    clipped = (code > FULL_SCALE_CODE) ? dvm_pkg::SAMPLE_W'(FULL_SCALE_CODE) : code;
    group_sum = group_sum + 13'(clipped);
    group_fill++;
    if (group_fill == GROUP_LEN) begin
      avg = 64'(group_sum) / 64'(GROUP_LEN);
      group_sum = '0;
      group_fill = 0;
      mv = (avg * 64'(gain_q16)) >> dvm_pkg::GAIN_FRAC_W;
      // The threshold sees the full scaled value, before any clamp.
      if (mv <= 64'(zero_thresh_mv)) begin
        ema_q2 = '0;
        r.voltage_mv = '0;
        r.below_threshold = 1'b1;
      end else begin
        mv = mv + 64'(diode_mv);
        if (ground_twice) begin
          mv = mv + 64'(diode_mv);
        end
        if (mv > 64'(MV_CEIL)) begin
          mv = 64'(MV_CEIL);
          clamped_count++;
        end
        mix = 64'd4 * mv + 64'd3 * 64'(ema_q2);
        ema_q2 = dvm_pkg::FILT_W'(mix >> 2);
        r.voltage_mv = ema_q2[dvm_pkg::FILT_W-1:2];
        r.below_threshold = 1'b0;
      end
      expected_readings.push_back(r);
    end
  endtask

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end
    if (roll < 85) begin
      return $urandom_range(1, 3);
    end
    if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch at reading %0d: %s", readings_seen, what);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sample driver. The predictor runs on the edge that takes a beat, so the
  // expectation is queued long before the block can answer it. A stalled
  // beat is simply held; valid only drops when a gap or an empty backlog
  // calls for it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_sample(in_adc_sample);
        samples_taken++;
        in_gap = pick_gap();
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0 || sample_backlog.size() == 0) begin
          if (in_gap > 0) begin
            in_gap--;
          end
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_adc_sample <= sample_backlog.pop_front();
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Each taken beat is held against the oldest expectation;
  // a beat with nothing waiting is a failure on its own. The sink stall is
  // drawn here too, in bursts of random length.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        readings_seen++;
        if (out_below_threshold === 1'b1) begin
          below_seen++;
        end
        if (expected_readings.size() == 0) begin
          note_mismatch($sformatf("unexpected beat voltage_mv=%0d below_threshold=%b",
                                  out_voltage_mv, out_below_threshold));
        end else begin
          want = expected_readings.pop_front();
          if (out_voltage_mv !== want.voltage_mv) begin
            note_mismatch($sformatf("voltage_mv expected %0d, got %0d",
                                    want.voltage_mv, out_voltage_mv));
          end
          if (out_below_threshold !== want.below_threshold) begin
            note_mismatch($sformatf("below_threshold expected %b, got %b",
                                    want.below_threshold, out_below_threshold));
          end
        end
      end
      if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: any stretch of cycles in which no beat moves on any channel
  // ends the run once it reaches the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: nothing moved for %0d cycles, %0d readings outstanding",
                 quiet_cycles, expected_readings.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_sample(input int unsigned code);
    sample_backlog.push_back(dvm_pkg::SAMPLE_W'(code));
    samples_queued++;
  endtask

  task automatic queue_group(input int unsigned a, input int unsigned b,
                             input int unsigned c, input int unsigned d,
                             input int unsigned e);
    push_sample(a);
    push_sample(b);
    push_sample(c);
    push_sample(d);
    push_sample(e);
  endtask

  // Blocks until every queued sample is taken and every reading is back,
  // then lets the pipe run dry through the settle wait.
  task automatic wait_quiet();
    do @(posedge clk);
    while (samples_taken != samples_queued || expected_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input dvm_pkg::cfg_reg_t idx,
                                input logic [dvm_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      dvm_pkg::CFG_SCALE_GAIN:   gain_q16 = value[dvm_pkg::GAIN_W-1:0];
      dvm_pkg::CFG_ZERO_THRESH:  zero_thresh_mv = value[dvm_pkg::THRESH_W-1:0];
      dvm_pkg::CFG_DIODE_OFFSET: diode_mv = value[dvm_pkg::OFFSET_W-1:0];
      dvm_pkg::CFG_GND_OFFSET:   ground_twice = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [dvm_pkg::GAIN_W-1:0] gain,
                               input logic [dvm_pkg::THRESH_W-1:0] thresh,
                               input logic [dvm_pkg::OFFSET_W-1:0] offset,
                               input logic twice, input bit calm);
    wait_quiet();
    write_register(dvm_pkg::CFG_SCALE_GAIN, dvm_pkg::CFG_DATA_W'(gain));
    write_register(dvm_pkg::CFG_ZERO_THRESH, dvm_pkg::CFG_DATA_W'(thresh));
    write_register(dvm_pkg::CFG_DIODE_OFFSET, dvm_pkg::CFG_DATA_W'(offset));
    write_register(dvm_pkg::CFG_GND_OFFSET, dvm_pkg::CFG_DATA_W'(twice));
    no_idle = calm;
    settings_used++;
  endtask

  // Smallest average code whose scaled value clears the threshold under the
  // current gain, so groups can straddle the zero decision.
  function automatic int unsigned boundary_code();
    logic [63:0] lvl;
    if (gain_q16 == 0) begin
      return $urandom_range(0, FULL_SCALE_CODE);
    end
    lvl = (((64'(zero_thresh_mv) + 64'd1) << dvm_pkg::GAIN_FRAC_W) +
           64'(gain_q16) - 64'd1) / 64'(gain_q16);
    if (lvl > 64'(FULL_SCALE_CODE)) begin
      return FULL_SCALE_CODE;
    end
    return int'(lvl);
  endfunction

  // Random groups of several flavors: independent codes, flat groups one
  // step either side of the threshold, a jittered random level, and rails.
  task automatic queue_random_samples(input int count);
    int unsigned mode;
    int unsigned level;
    int unsigned jitter;
    int          code;
    int          k;
    while (count > 0) begin
      mode = $urandom_range(0, 9);
      if (mode >= 4 && mode < 7) begin
        level = boundary_code();
        case ($urandom_range(0, 2))
          0: if (level > 0) level--;
          2: if (level < FULL_SCALE_CODE) level++;
          default: ;
        endcase
      end else begin
        level = $urandom_range(0, FULL_SCALE_CODE);
      end
      for (k = 0; k < GROUP_LEN && count > 0; k++) begin
        if (mode < 4) begin
          code = $urandom_range(0, FULL_SCALE_CODE);
        end else if (mode < 7) begin
          code = level;
        end else if (mode < 9) begin
          jitter = $urandom_range(0, 6);
          code = int'(level) + int'(jitter) - 3;
          if (code < 0) code = 0;
          if (code > FULL_SCALE_CODE) code = FULL_SCALE_CODE;
        end else begin
          code = $urandom_range(0, 1) ? FULL_SCALE_CODE : 0;
        end
        push_sample(code);
        count--;
      end
    end
  endtask

  task automatic random_setting(input bit calm);
    logic [dvm_pkg::GAIN_W-1:0]   gain;
    logic [dvm_pkg::THRESH_W-1:0] thresh;
    case ($urandom_range(0, 3))
      0: gain = $urandom;
      1: gain = $urandom_range(32'h0001_0000, 32'h0020_0000);
      2: gain = $urandom_range(0, 32'h0001_0000);
      default: gain = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
    endcase
    case ($urandom_range(0, 5))
      0, 1: thresh = dvm_pkg::THRESH_W'($urandom_range(0, 65535));
      2, 3: thresh = dvm_pkg::THRESH_W'($urandom_range(0, 2000));
      4: thresh = '0;
      default: thresh = '1;
    endcase
    apply_setting(gain, thresh, dvm_pkg::OFFSET_W'($urandom_range(0, 4095)),
                  1'($urandom_range(0, 1)), calm);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    int p;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: 5 mV per step, 500 mV threshold, one 700 mV drop.
    // All-zero group reads as zero; full-scale group lands well above it.
    queue_group(0, 0, 0, 0, 0);
    queue_group(1023, 1023, 1023, 1023, 1023);
    // Average truncates to 100, scaling to exactly the threshold: still zero.
    queue_group(100, 100, 100, 100, 104);
    // One step higher is 505 mV and starts the filter from zero.
    queue_group(101, 101, 101, 101, 105);
    // Alternating bit patterns on the sample port.
    queue_group(10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h3FF);
    queue_random_samples(150);

    // Largest gain, threshold at the top: an average of one scales to
    // exactly 65535 and reads as zero, two clears it and then saturates
    // with both diode drops added.
    apply_setting('1, '1, '1, 1'b1, 1'b0);
    queue_group(1, 1, 1, 1, 1);
    queue_group(2, 2, 2, 2, 2);
    queue_group(1023, 1023, 1023, 1023, 1023);
    queue_group(0, 0, 0, 0, 0);
    queue_random_samples(60);

    // Zero gain with zero threshold: everything reads as zero.
    apply_setting('0, '0, '0, 1'b0, 1'b1);
    queue_random_samples(40);

    // Unity gain and no offsets: the filter tracks the raw average.
    apply_setting(32'h0001_0000, '0, '0, 1'b0, 1'b0);
    queue_group(0, 0, 0, 0, 0);
    queue_group(1, 1, 1, 1, 1);
    queue_random_samples(60);

    // Largest gain, zero threshold, no offsets: heavy saturation.
    apply_setting('1, '0, '0, 1'b0, 1'b0);
    queue_random_samples(60);

    for (p = 0; p < 8; p++) begin
      random_setting(p % 3 == 1);
      queue_random_samples(140);
    end

    wait_quiet();
    mismatches += expected_readings.size();

    $display("Ran %0d samples into %0d readings (%0d below threshold, %0d clamped)",
             samples_taken, readings_seen, below_seen, clamped_count);
    $display("across %0d register settings; %0d mismatches", settings_used, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/dvm_pkg.sv
rtl/divided_voltage_monitor.sv
tb/tb_top.sv
